// File: sv/mbso_pkg.sv
// ----------------------------------------------------------------------------
// mbso_pkg
// shared constants, the 2^frac mantissa table and the target point selection
// ----------------------------------------------------------------------------
package mbso_pkg;

  localparam int NUM_SEGMENTS    = 4;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int NPTS            = 4 * NUM_SEGMENTS;
  localparam int PT_W            = $clog2(NPTS);
  localparam int SEG_W           = $clog2(NUM_SEGMENTS);
  localparam int EXP_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int FRAC_W          = 24;
  localparam int PH_W            = FRAC_W + SEG_W;
  localparam int MANT_W          = 17;

  localparam longint unsigned LN2_Q30 = 64'd744261118;

  localparam logic [1:0] STYLE_SMOOTH = 2'd0;
  localparam logic [1:0] STYLE_HALF   = 2'd1;
  localparam logic [1:0] STYLE_WILD   = 2'd2;

  typedef logic [MANT_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // 2^(k/depth) in q16, taylor series of exp in q30, each term truncated
  function automatic exp_tab_t exp_tab_build();
    exp_tab_t          tab;
    longint unsigned   y;
    longint unsigned   sum;
    longint unsigned   term;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      y    = (LN2_Q30 * 64'(k)) / EXP_TABLE_DEPTH;
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        sum  = sum + term;
      end
      tab[k] = MANT_W'((sum + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_build();

  typedef enum logic [2:0] {
    SRC_WORD,
    SRC_PREV,
    SRC_MIRROR_PREV,
    SRC_MIRROR_FIRST,
    SRC_FIRST
  } src_kind_e;

  typedef struct packed {
    src_kind_e  kind;
    logic [3:0] word;
  } tgt_src_t;

  // where target point idx comes from in the given style
  function automatic tgt_src_t tgt_src(input logic [1:0] style, input logic [PT_W-1:0] idx);
    tgt_src_t s;
    int       k;
    int       j;
    int       w;
    k      = int'(idx) >> 2;
    j      = int'(idx) & 3;
    w      = 0;
    s.kind = SRC_WORD;
    s.word = 4'(idx);
    if (k == 0 || style >= STYLE_WILD) begin
      s.kind = SRC_WORD;
    end else if (k == NUM_SEGMENTS - 1) begin
      case (j)
        0:       s.kind = SRC_PREV;
        1:       s.kind = SRC_MIRROR_PREV;
        2:       s.kind = SRC_MIRROR_FIRST;
        default: s.kind = SRC_FIRST;
      endcase
    end else if (style == STYLE_HALF && k < NUM_SEGMENTS - 2) begin
      s.kind = SRC_WORD;
    end else begin
      w = (style == STYLE_HALF) ? 4 * k : 2 * k + 2;
      case (j)
        0:       s.kind = SRC_PREV;
        1:       s.kind = SRC_MIRROR_PREV;
        2: begin
          s.kind = SRC_WORD;
          s.word = 4'(w);
        end
        default: begin
          s.kind = SRC_WORD;
          s.word = 4'(w + 1);
        end
      endcase
    end
    return s;
  endfunction

endpackage

// File: sv/morphing_bezier_spline_oscillator.sv
// ----------------------------------------------------------------------------
// morphing_bezier_spline_oscillator
// bezier spline oscillator whose control points glide toward random targets
// ----------------------------------------------------------------------------
// Each tick item (tuser = 0) yields one sample item, each load item (tuser = 1)
// writes one staging word and yields nothing. A load keeps the sequencer idle,
// so loads can follow back to back. A tick runs pitch lookup, multiply and
// phase, Bezier weights on one shared 25x25 multiplier, the four-point dot
// product, the output register and a read-modify-write sweep of the point
// memory. A tick that starts a new glide (morph counter at zero) first computes
// each point's increment with a 34-step restoring divider. Control points,
// increments and staging words live in synchronous memories with registered
// reads; per-entry valid bits make unwritten entries read as zero, so there is
// no clearing pass. A finished sample waits in the output register while the
// next item is taken.
module morphing_bezier_spline_oscillator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pitch_cv[15:0], rnd_index[19:16], rnd_value[35:20]
  input  logic        s_axis_tuser,   // op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // sample[15:0]
);
  import mbso_pkg::*;

  // register indexes
  localparam logic [1:0] REG_MORPH_STEPS = 2'd0;
  localparam logic [1:0] REG_STYLE       = 2'd1;
  localparam logic [1:0] REG_PITCH_OFF   = 2'd2;
  localparam logic [1:0] REG_BASE_INC    = 2'd3;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXP   = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_PHASE = 4'd3;
  localparam logic [3:0] ST_TRD   = 4'd4;
  localparam logic [3:0] ST_TCALC = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_TWR   = 4'd7;
  localparam logic [3:0] ST_WGT   = 4'd8;
  localparam logic [3:0] ST_ACC   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;
  localparam logic [3:0] ST_UPD   = 4'd11;

  localparam int DIV_N = 34;
  localparam logic signed [32:0] HALF_RANGE = 33'sd671088640;

  // configuration
  logic [12:0]        steps_q;
  logic [1:0]         style_q;
  logic signed [14:0] poff_q;
  logic [23:0]        base_q;

  // control
  logic [3:0]         state_q;
  logic [12:0]        lat_q;
  logic [12:0]        mc_q;
  logic [PH_W-1:0]    phase_q;
  logic [SEG_W-1:0]   seg_q;
  logic [23:0]        t_q;
  logic [PT_W-1:0]    pt_q;
  logic [5:0]         dcnt_q;
  logic [2:0]         wcnt_q;
  logic [2:0]         acnt_q;
  logic [PT_W:0]      ucnt_q;
  logic               m_vld_q;

  // datapath registers
  logic signed [15:0] cv_q;
  logic signed [4:0]  oct_q;
  logic [MANT_W-1:0]  mant_q;
  logic [24:0]        inc0_q;
  logic signed [32:0] h1_q, h2_q, h3_q, tg0_q, tg1_q;
  logic [12:0]        rem_q;
  logic [33:0]        quo_q;
  logic               neg_q;
  logic [24:0]        t2_q, tm2_q;
  logic [25:0]        w_q [4];
  logic signed [58:0] prod_q;
  logic signed [59:0] acc_q;
  logic [15:0]        out_q;

  // memories
  logic [31:0]        cur_mem [NPTS];
  logic [31:0]        inc_mem [NPTS];
  logic [15:0]        stg_mem [16];
  logic [NPTS-1:0]    cur_vld_q, inc_vld_q;
  logic [15:0]        stg_vld_q;
  logic               cur_ok_q, inc_ok_q, stg_ok_q;
  logic [31:0]        cur_raw_q, inc_raw_q;
  logic [15:0]        stg_raw_q;
  logic [PT_W-1:0]    cur_ra, cur_wa, inc_wa;
  logic [3:0]         stg_ra;
  logic               cur_we, inc_we, stg_we;
  logic [31:0]        cur_wd, inc_wd, cur_rd, inc_rd;
  logic [15:0]        stg_rd;

  logic in_acc, tick_acc, out_ld;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick_acc      = in_acc && !s_axis_tuser;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = out_q;

  assign cur_rd = cur_ok_q ? cur_raw_q : 32'd0;
  assign inc_rd = inc_ok_q ? inc_raw_q : 32'd0;
  assign stg_rd = stg_ok_q ? stg_raw_q : 16'd0;

  // ---- pitch: saturate, split into octave and table index
  logic signed [16:0] e_sum, e_sat, ue_w;
  logic [15:0]        ue;
  logic [EXP_W-1:0]   exp_k;
  always_comb begin
    e_sum = 17'(poff_q) + 17'(cv_q);
    if (e_sum > 17'sd28672)       e_sat = 17'sd28672;
    else if (e_sum < -17'sd28672) e_sat = -17'sd28672;
    else                          e_sat = e_sum;
    ue_w  = e_sat + 17'sd32768;
    ue    = ue_w[15:0];
    exp_k = ue[11 -: EXP_W];
  end

  // ---- phase advance and wrap
  logic [31:0]       inc_sh;
  logic [4:0]        oct_neg;
  logic [32:0]       psum;
  logic              wrap;
  always_comb begin
    oct_neg = 5'(-oct_q);
    if (!oct_q[4]) inc_sh = 32'(inc0_q) << oct_q[2:0];
    else           inc_sh = 32'(inc0_q) >> oct_neg[2:0];
    psum = 33'(phase_q) + 33'(inc_sh);
    wrap = (psum[32:24] >= 9'(NUM_SEGMENTS));
  end

  // ---- target point and difference to the current point
  tgt_src_t           src;
  logic [30:0]        wprod;
  logic signed [32:0] wpt, tgt;
  logic signed [33:0] diff;
  logic [33:0]        mag;
  always_comb begin
    src   = tgt_src(style_q, pt_q);
    wprod = 31'(stg_rd) * 31'd20480;
    wpt   = $signed({2'b00, wprod}) - HALF_RANGE;
    case (src.kind)
      SRC_WORD:         tgt = wpt;
      SRC_PREV:         tgt = h1_q;
      SRC_MIRROR_PREV:  tgt = (h1_q <<< 1) - h3_q;
      SRC_MIRROR_FIRST: tgt = (tg0_q <<< 1) - tg1_q;
      SRC_FIRST:        tgt = tg0_q;
      default:          tgt = wpt;
    endcase
    diff = {tgt[32], tgt} - {{2{cur_rd[31]}}, cur_rd};
    mag  = diff[33] ? 34'(-diff) : 34'(diff);
  end

  // ---- restoring divider step
  logic [12:0] dvs;
  logic [13:0] rsh;
  logic        ge;
  logic [33:0] qv;
  always_comb begin
    dvs = (lat_q == 13'd0) ? 13'd1 : lat_q;
    rsh = {rem_q, quo_q[33]};
    ge  = (rsh >= {1'b0, dvs});
    qv  = neg_q ? 34'(-quo_q) : quo_q;
  end

  // ---- shared weight multiplier
  logic [24:0] tm, mul_a, mul_b, mul_s;
  logic [49:0] mul_p;
  always_comb begin
    tm = 25'(1 << FRAC_W) - 25'(t_q);
    case (wcnt_q)
      3'd0:    begin mul_a = 25'(t_q); mul_b = 25'(t_q); end
      3'd1:    begin mul_a = tm;       mul_b = tm;       end
      3'd2:    begin mul_a = t2_q;     mul_b = 25'(t_q); end
      3'd3:    begin mul_a = tm2_q;    mul_b = tm;       end
      3'd4:    begin mul_a = tm2_q;    mul_b = 25'(t_q); end
      default: begin mul_a = tm;       mul_b = t2_q;     end
    endcase
    mul_p = mul_a * mul_b;
    mul_s = mul_p[48:24];
  end

  // ---- dot product and output rounding
  logic [1:0]         wsel;
  logic signed [59:0] acc_r;
  logic signed [19:0] rq;
  logic [15:0]        sat;
  always_comb begin
    wsel  = 2'(acnt_q - 3'd1);
    acc_r = acc_q + (60'sd1 <<< 39);
    rq    = 20'(acc_r >>> 40);
    if (rq > 20'sd32767)       sat = 16'h7fff;
    else if (rq < -20'sd32768) sat = 16'h8000;
    else                       sat = rq[15:0];
  end

  assign out_ld = (state_q == ST_OUT) && (!m_vld_q || m_axis_tready);

  // ---- memory ports
  always_comb begin
    case (state_q)
      ST_ACC:  cur_ra = {seg_q, acnt_q[1:0]};
      ST_UPD:  cur_ra = ucnt_q[PT_W-1:0];
      default: cur_ra = pt_q;
    endcase
    cur_we = (state_q == ST_UPD) && (ucnt_q != '0);
    cur_wa = PT_W'(ucnt_q - 1'b1);
    cur_wd = cur_rd + inc_rd;
    inc_we = (state_q == ST_TWR);
    inc_wa = pt_q;
    inc_wd = qv[31:0];
    stg_we = in_acc && s_axis_tuser;
    stg_ra = src.word;
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_raw_q <= cur_mem[cur_ra];
    if (inc_we) inc_mem[inc_wa] <= inc_wd;
    inc_raw_q <= inc_mem[cur_ra];
    if (stg_we) stg_mem[s_axis_tdata[19:16]] <= s_axis_tdata[35:20];
    stg_raw_q <= stg_mem[stg_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      inc_vld_q <= '0;
      stg_vld_q <= '0;
      cur_ok_q  <= 1'b0;
      inc_ok_q  <= 1'b0;
      stg_ok_q  <= 1'b0;
    end else begin
      if (cur_we) cur_vld_q[cur_wa] <= 1'b1;
      if (inc_we) inc_vld_q[inc_wa] <= 1'b1;
      if (stg_we) stg_vld_q[s_axis_tdata[19:16]] <= 1'b1;
      cur_ok_q <= cur_vld_q[cur_ra];
      inc_ok_q <= inc_vld_q[cur_ra];
      stg_ok_q <= stg_vld_q[stg_ra];
    end
  end

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 13'd2000;
      style_q <= STYLE_SMOOTH;
      poff_q  <= 15'sd0;
      base_q  <= 24'd365702;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MORPH_STEPS: steps_q <= cfg_data_i[12:0];
        REG_STYLE:       style_q <= cfg_data_i[1:0];
        REG_PITCH_OFF:   poff_q  <= $signed(cfg_data_i[14:0]);
        REG_BASE_INC:    base_q  <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // ---- sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lat_q   <= '0;
      mc_q    <= '0;
      phase_q <= '0;
      seg_q   <= '0;
      pt_q    <= '0;
      dcnt_q  <= '0;
      wcnt_q  <= '0;
      acnt_q  <= '0;
      ucnt_q  <= '0;
      m_vld_q <= 1'b0;
    end else begin
      // output register: load a new sample or drop the one taken
      if (out_ld) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (tick_acc) state_q <= ST_EXP;
        ST_EXP:  state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_PHASE;
        ST_PHASE: begin
          phase_q <= wrap ? PH_W'(psum[23:0]) : psum[PH_W-1:0];
          seg_q   <= wrap ? '0 : psum[24 +: SEG_W];
          wcnt_q  <= '0;
          pt_q    <= '0;
          if (mc_q == 13'd0) begin
            lat_q   <= steps_q;
            state_q <= ST_TRD;
          end else begin
            state_q <= ST_WGT;
          end
        end
        ST_TRD:   state_q <= ST_TCALC;
        ST_TCALC: begin
          dcnt_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(DIV_N - 1)) state_q <= ST_TWR;
        end
        ST_TWR: begin
          pt_q <= pt_q + 1'b1;
          if (pt_q == PT_W'(NPTS - 1)) state_q <= ST_WGT;
          else                         state_q <= ST_TRD;
        end
        ST_WGT: begin
          wcnt_q <= wcnt_q + 3'd1;
          if (wcnt_q == 3'd5) begin
            acnt_q  <= '0;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          acnt_q <= acnt_q + 3'd1;
          if (acnt_q == 3'd5) state_q <= ST_OUT;
        end
        ST_OUT: if (out_ld) begin
          ucnt_q  <= '0;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          ucnt_q <= ucnt_q + 1'b1;
          if (ucnt_q == (PT_W+1)'(NPTS)) begin
            mc_q    <= (mc_q >= lat_q) ? 13'd0 : mc_q + 13'd1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (tick_acc) cv_q <= $signed(s_axis_tdata[15:0]);
    if (state_q == ST_EXP) begin
      mant_q <= EXP_TAB[exp_k];
      oct_q  <= $signed({1'b0, ue[15:12]}) - 5'sd8;
    end
    if (state_q == ST_MUL) inc0_q <= 25'((41'(base_q) * 41'(mant_q)) >> 16);
    if (state_q == ST_PHASE) t_q <= psum[23:0];
    if (state_q == ST_TCALC) begin
      h1_q  <= tgt;
      h2_q  <= h1_q;
      h3_q  <= h2_q;
      if (pt_q == PT_W'(0)) tg0_q <= tgt;
      if (pt_q == PT_W'(1)) tg1_q <= tgt;
      rem_q <= '0;
      quo_q <= mag;
      neg_q <= diff[33];
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? 13'(rsh - {1'b0, dvs}) : rsh[12:0];
      quo_q <= {quo_q[32:0], ge};
    end
    if (state_q == ST_WGT) begin
      case (wcnt_q)
        3'd0:    t2_q   <= mul_s;
        3'd1:    tm2_q  <= mul_s;
        3'd2:    w_q[3] <= 26'(mul_s);
        3'd3:    w_q[0] <= 26'(mul_s);
        3'd4:    w_q[1] <= 26'(mul_s) + {mul_s, 1'b0};
        default: w_q[2] <= 26'(mul_s) + {mul_s, 1'b0};
      endcase
      acc_q <= '0;
    end
    if (state_q == ST_ACC) begin
      if (acnt_q >= 3'd1 && acnt_q <= 3'd4)
        prod_q <= 59'($signed(cur_rd) * $signed({1'b0, w_q[wsel]}));
      if (acnt_q >= 3'd2) acc_q <= acc_q + 60'(prod_q);
    end
    if (out_ld) out_q <= sat;
  end

  // ---- assertions
  a_mc_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mc_q <= lat_q) else $error("morph counter beyond latched steps");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q[PH_W-1:FRAC_W] < SEG_W'(NUM_SEGMENTS - 1) ||
    phase_q[PH_W-1:FRAC_W] == SEG_W'(NUM_SEGMENTS - 1))
    else $error("phase segment out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> !(m_vld_q && !m_axis_tready)) else $error("result overwritten");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> state_q == ST_EXP) else $error("tick not started");

endmodule

// File: verif/tb_morphing_bezier_spline_oscillator.sv
// ----------------------------------------------------------------------------
// tb_morphing_bezier_spline_oscillator
// self-checking bench: a directed table, then randomized phases under several
// register settings; each sample item is checked against its typed value or a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_morphing_bezier_spline_oscillator;
  import mbso_pkg::*;

  // register indexes
  localparam logic [1:0] REG_MORPH_STEPS = 2'd0;
  localparam logic [1:0] REG_STYLE       = 2'd1;
  localparam logic [1:0] REG_PITCH_OFS   = 2'd2;
  localparam logic [1:0] REG_BASE_INC    = 2'd3;
  // the unused style code behaves as wild
  localparam logic [1:0] STYLE_SPARE     = 2'd3;

  typedef enum bit {OP_TICK = 1'b0, OP_LOAD = 1'b1} op_e;

  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 3000;
  localparam int SETTLE_CYC  = 700;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // pitch_cv[15:0], rnd_index[19:16], rnd_value[35:20]
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // sample[15:0]

  morphing_bezier_spline_oscillator dut (.*);

  // ---------------------------------------------------------------- predictor
  logic [12:0]        steps_reg;
  logic [1:0]         style_reg;
  logic signed [14:0] ofs_reg;
  logic [23:0]        base_reg;
  logic signed [31:0] pts[NPTS];
  logic signed [31:0] glide_inc[NPTS];
  logic [15:0]        staging[16];
  longint             osc_phase;
  int                 morph_cnt;
  int                 held_steps;

  logic signed [15:0] sample_q[$];   // samples still to arrive
  int                 n_errors;
  int                 n_items, n_ticks, n_samples, n_glides;

  function automatic longint pow2_q16(longint k);
    longint unsigned y, acc, term;
    y = (LN2_Q30 * longint'(k)) / EXP_TABLE_DEPTH;
    acc = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * y) >> 30) / n;
      acc  = acc + term;
    end
    return longint'((acc + 64'd8192) >> 14);
  endfunction

  function automatic longint word_to_point(int i);
    return longint'(staging[i & 15]) * 20480 - 64'sd671088640;
  endfunction

  // target spline for the current style and staging words
  task automatic build_spline(output longint tg[NPTS]);
    int w;
    for (int j = 0; j < 4; j++) tg[j] = word_to_point(j);
    for (int k = 1; k < NUM_SEGMENTS; k++) begin
      if (style_reg >= STYLE_WILD) begin
        for (int j = 0; j < 4; j++) tg[4*k+j] = word_to_point(4*k+j);
      end else if (k == NUM_SEGMENTS - 1) begin
        // loop closure back to the first knot
        tg[4*k]   = tg[4*k-1];
        tg[4*k+1] = 2 * tg[4*k-1] - tg[4*k-2];
        tg[4*k+2] = 2 * tg[0] - tg[1];
        tg[4*k+3] = tg[0];
      end else if (style_reg == STYLE_HALF && k < NUM_SEGMENTS - 2) begin
        for (int j = 0; j < 4; j++) tg[4*k+j] = word_to_point(4*k+j);
      end else begin
        w = (style_reg == STYLE_HALF) ? 4 * k : 2 * k + 2;
        tg[4*k]   = tg[4*k-1];
        tg[4*k+1] = 2 * tg[4*k-1] - tg[4*k-2];
        tg[4*k+2] = word_to_point(w);
        tg[4*k+3] = word_to_point(w + 1);
      end
    end
  endtask

  // one tick: returns the sample and advances the glide
  task automatic osc_tick(input logic signed [15:0] cv, output logic signed [15:0] smp);
    longint e, mant, step, p, seg, t, tm, t2, t3, tm2, tm3, acc, r, dv;
    longint w[4];
    longint tg[NPTS];
    int     oct;
    e = longint'(ofs_reg) + longint'(cv);
    if (e > 28672) e = 28672;
    if (e < -28672) e = -28672;
    e = e + 32768;
    oct = int'(e >> 12) - 8;
    mant = pow2_q16(((e & 4095) * EXP_TABLE_DEPTH) >> 12);
    step = (longint'(base_reg) * mant) >> 16;
    if (oct >= 0) step = step << oct;
    else step = step >> (-oct);
    p = osc_phase + step;
    seg = p >> 24;
    t = p & 64'hFFFFFF;
    if (seg >= NUM_SEGMENTS) begin
      seg = 0;
      osc_phase = t;
    end else begin
      osc_phase = p;
    end
    if (morph_cnt == 0) begin
      build_spline(tg);
      held_steps = steps_reg;
      dv = held_steps ? held_steps : 1;
      n_glides++;
      for (int i = 0; i < NPTS; i++) glide_inc[i] = 32'((tg[i] - longint'(pts[i])) / dv);
    end
    tm  = (64'd1 << 24) - t;
    t2  = (t * t) >> 24;
    t3  = (t2 * t) >> 24;
    tm2 = (tm * tm) >> 24;
    tm3 = (tm2 * tm) >> 24;
    w[0] = tm3;
    w[1] = 3 * ((tm2 * t) >> 24);
    w[2] = 3 * ((tm * t2) >> 24);
    w[3] = t3;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += longint'(pts[4*seg+i]) * w[i];
    // round half up, floor shift, then saturate
    r = (acc + (64'sd1 <<< 39)) >>> 40;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    smp = 16'(r);
    for (int i = 0; i < NPTS; i++) pts[i] = pts[i] + glide_inc[i];
    if (morph_cnt >= held_steps) morph_cnt = 0;
    else morph_cnt++;
  endtask

  // ------------------------------------------------------------- clock, reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_MORPH_STEPS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ------------------------------------------------------------------ receiver
  bit quiet;        // no stalls on either side
  bit hold_req;     // ask the receiver for one long hold-off
  int hold_left;
  int rr;

  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      rr = $urandom_range(99);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (quiet || rr < 70) begin
        m_axis_tready = 1'b1;
      end else if (rr < 96) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b0;
        hold_left = $urandom_range(10, 80);
      end
    end
  end

  // sample checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_samples++;
      if (sample_q.size() == 0) begin
        n_errors++;
        $error("sample %0d arrived with nothing expected", $signed(m_axis_tdata));
      end else begin
        if (m_axis_tdata !== sample_q[0]) begin
          n_errors++;
          $error("sample mismatch: expected %0d, actual %0d",
                 sample_q[0], $signed(m_axis_tdata));
        end
        void'(sample_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cyc;
  initial begin
    idle_cyc = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("morphing_bezier_spline_oscillator test failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------- sender
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MORPH_STEPS: steps_reg = val[12:0];
      REG_STYLE:       style_reg = val[1:0];
      REG_PITCH_OFS:   ofs_reg   = val[14:0];
      default:         base_reg  = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one item; a typed expectation overrides the predicted sample
  task automatic send_item(input op_e op, input logic [15:0] cv, input logic [3:0] idx,
                           input logic [15:0] val, input int gap,
                           input bit has_exp = 1'b0, input logic [15:0] exp_val = '0);
    logic signed [15:0] smp;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'b0, val, idx, cv};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (op == OP_LOAD) begin
      staging[idx] = val;
    end else begin
      n_ticks++;
      osc_tick(cv, smp);
      sample_q.push_back(has_exp ? exp_val : smp);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int g;
    g = $urandom_range(99);
    if (quiet || g < 60) return 0;
    if (g < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  // wait for every sample, then let any trailing glide work finish
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sample_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  typedef struct {
    op_e         op;
    logic [15:0] cv;
    logic [3:0]  idx;
    logic [15:0] val;
    bit          has_exp;
    logic [15:0] exp_val;
  } row_t;

  // directed rows at reset settings; only the first sample is obvious
  // (all points start at zero)
  row_t dir_rows[] = '{
    '{OP_TICK, 16'h0000, 4'd0,  16'h0000, 1'b1, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_LOAD, 16'hFFFF, 4'd15, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd5,  16'h5555, 1'b0, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd10, 16'hAAAA, 1'b0, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd1,  16'hFFFF, 1'b0, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd7,  16'h8000, 1'b0, 16'h0000},
    '{OP_TICK, 16'h7000, 4'd0,  16'h0000, 1'b0, 16'h0000},   // +7 V
    '{OP_TICK, 16'h9000, 4'd0,  16'h0000, 1'b0, 16'h0000},   // -7 V
    '{OP_TICK, 16'hFFFF, 4'd3,  16'h1234, 1'b0, 16'h0000},
    '{OP_TICK, 16'h0FFF, 4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_TICK, 16'h1000, 4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_TICK, 16'h0000, 4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_LOAD, 16'h0000, 4'd8,  16'h0001, 1'b0, 16'h0000},
    '{OP_TICK, 16'hF001, 4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_TICK, 16'h6FFF, 4'd0,  16'h0000, 1'b0, 16'h0000}
  };

  typedef struct {
    logic [12:0] steps;
    logic [1:0]  style;
    int          ofs;
    int          base;
    int          count;
    bit          calm;
  } phase_t;

  phase_t phases[6];
  int     ofs_r, base_r, load_pct;
  logic [15:0] cv_r;

  initial begin
    n_errors = 0;
    n_items = 0; n_ticks = 0; n_samples = 0; n_glides = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    steps_reg = 13'd2000;
    style_reg = STYLE_SMOOTH;
    ofs_reg   = '0;
    base_reg  = 24'd365702;
    for (int i = 0; i < NPTS; i++) begin
      pts[i] = '0;
      glide_inc[i] = '0;
    end
    for (int i = 0; i < 16; i++) staging[i] = '0;
    osc_phase = 0;
    morph_cnt = 0;
    held_steps = 0;

    ofs_r  = $urandom_range(0, 28672) - 14336;
    base_r = $urandom_range(0, 24'hFFFFFF);
    phases[0] = '{13'd100,  STYLE_HALF,   -14336, 1000000,  120, 1'b0};
    phases[1] = '{13'd5000, STYLE_WILD,    14336, 24'hFFFFFF, 80, 1'b1};
    // zero steps: a new target on every tick
    phases[2] = '{13'd0,    STYLE_SPARE,   0,     0,          15, 1'b0};
    phases[3] = '{13'd150,  STYLE_SMOOTH,  ofs_r, base_r,    180, 1'b0};
    phases[4] = '{13'd100,  STYLE_HALF,
                  $urandom_range(0, 28672) - 14336, $urandom_range(0, 24'hFFFFFF), 140, 1'b0};
    phases[5] = '{13'd4000, STYLE_SMOOTH, -1, 24'h555555, 30, 1'b0};

    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].cv, dir_rows[i].idx, dir_rows[i].val,
                pick_gap(), dir_rows[i].has_exp, dir_rows[i].exp_val);
    // the sender waits here for every sample before touching registers
    drain();

    foreach (phases[p]) begin
      write_reg(REG_MORPH_STEPS, 24'(phases[p].steps));
      write_reg(REG_STYLE,       24'(phases[p].style));
      write_reg(REG_PITCH_OFS,   24'(phases[p].ofs) & 24'h7FFF);
      write_reg(REG_BASE_INC,    24'(phases[p].base));
      quiet = phases[p].calm;
      load_pct = $urandom_range(25, 50);
      for (int n = 0; n < phases[p].count; n++) begin
        // long receiver hold-off while items keep coming
        if (p == 3 && n == 40) hold_req = 1'b1;
        if ($urandom_range(99) < load_pct) begin
          send_item(OP_LOAD, 16'($urandom), 4'($urandom), 16'($urandom), pick_gap());
        end else begin
          if ($urandom_range(9) == 0) cv_r = 16'($urandom_range(0, 256)) - 16'd128;
          else cv_r = 16'($urandom_range(0, 57344) - 28672);
          send_item(OP_TICK, cv_r, 4'($urandom), 16'($urandom), pick_gap());
        end
      end
      quiet = 1'b0;
      drain();
    end

    $display("covered %0d items (%0d ticks, %0d loads), %0d samples checked",
             n_items, n_ticks, n_items - n_ticks, n_samples);
    $display("glides started: %0d over %0d register settings, all styles", n_glides, 7);
    if (n_errors == 0) begin
      $display("morphing_bezier_spline_oscillator test passed");
    end else begin
      $display("morphing_bezier_spline_oscillator test failed");
    end
    $finish;
  end

endmodule

// File: morphing_bezier_spline_oscillator.f
sv/mbso_pkg.sv
sv/morphing_bezier_spline_oscillator.sv
verif/tb_morphing_bezier_spline_oscillator.sv
